// ----- design/multiplexed_clock_display_scanner_assert.svh -----
// assertion macros for the clock display scanner
`ifndef MULTIPLEXED_CLOCK_DISPLAY_SCANNER_ASSERT_SVH
`define MULTIPLEXED_CLOCK_DISPLAY_SCANNER_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent holds -> consequent holds in the same cycle
`define MCDS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// antecedent holds -> consequent holds in the next cycle
`define MCDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define MCDS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define MCDS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- design/mcds_pkg.sv -----
`default_nettype none

package mcds_pkg;

    typedef enum logic [1:0] {
        OP_SET_TIME = 2'd0,
        OP_SCAN     = 2'd1,
        OP_BLINK    = 2'd2
    } t_op;

    localparam logic [2:0]  POS_LAST   = 3'd4;
    localparam logic [2:0]  POS_COLON  = 3'd2;
    localparam logic [15:0] COLON_MASK = 16'h1040;

    typedef struct packed {
        logic [3:0] tens;
        logic [3:0] units;
    } t_digits;

    // decimal split of a 7-bit value: units and (value / 10) mod 10
    function automatic t_digits f_split(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  q;
        logic [7:0]  rem;
        t_digits     d;
        prod    = 15'(v) * 15'd205;   // 205 / 2048 ~ 1 / 10, exact for 0..127
        q       = prod[14:11];
        rem     = {1'b0, v} - ({4'b0, q} * 8'd10);
        d.units = rem[3:0];
        d.tens  = (q >= 4'd10) ? (q - 4'd10) : q;
        return d;
    endfunction

    function automatic logic [15:0] f_sel_mask(input logic [2:0] pos);
        logic [15:0] m;
        unique case (pos)
            3'd0:    m = 16'h0002;
            3'd1:    m = 16'h0020;
            3'd2:    m = 16'h0080;
            3'd3:    m = 16'h0400;
            3'd4:    m = 16'h2000;
            default: m = 16'h0000;
        endcase
        return m;
    endfunction

    function automatic logic [15:0] f_seg(input logic [3:0] digit);
        logic [15:0] s;
        unique case (digit)
            4'd0:    s = 16'h095C;
            4'd1:    s = 16'h0110;
            4'd2:    s = 16'h1854;
            4'd3:    s = 16'h1154;
            4'd4:    s = 16'h1118;
            4'd5:    s = 16'h114C;
            4'd6:    s = 16'h194C;
            4'd7:    s = 16'h011C;
            4'd8:    s = 16'h195C;
            4'd9:    s = 16'h115C;
            default: s = 16'h0000;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- design/multiplexed_clock_display_scanner.sv -----
// path: a beat is held in the input register stage, and a scan beat then loads the result register
// throughput: one beat per cycle, set-time, blink and scan alike, while a scan result is not held up by the output
// only scan beats produce an output beat; set-time and blink just update the state
// reset (i_rst_n low, synchronous): both stages empty, digits zero, colon off,
// scan position zero so the first scan drives position 1
`default_nettype none

module multiplexed_clock_display_scanner (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_op,
    input  wire logic [6:0]  i_hours,
    input  wire logic [6:0]  i_minutes,
    // output channel
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [15:0]      o_drive_word,
    output logic [2:0]       o_scan_position
);

`include "multiplexed_clock_display_scanner_assert.svh"

    // ---- input register stage ----
    logic       r_in_valid;
    logic [1:0] r_op;
    logic [6:0] r_hours;
    logic [6:0] r_minutes;

    // ---- display state ----
    logic [3:0] r_digits [4];   // 0 min units, 1 min tens, 2 hour units, 3 hour tens
    logic       r_colon;
    logic [2:0] r_position;

    // ---- result register ----
    logic        r_out_valid;
    logic [15:0] r_drive_word;
    logic [2:0]  r_scan_position;

    logic              is_scan;
    logic              advance;
    logic              scan_step;
    logic              in_accept;
    logic [2:0]        n_position;
    logic [15:0]       n_word;
    mcds_pkg::t_digits split_h;
    mcds_pkg::t_digits split_m;

    assign is_scan   = (r_op == mcds_pkg::OP_SCAN);
    // the held beat moves on unless it carries a result and the output is blocked
    assign advance   = !is_scan || !r_out_valid || i_ready;
    assign o_ready   = !r_in_valid || advance;
    assign in_accept = i_valid && o_ready;
    // a scan beat leaving the input stage loads the result register
    assign scan_step = r_in_valid && advance && is_scan;

    assign split_h = mcds_pkg::f_split(r_hours);
    assign split_m = mcds_pkg::f_split(r_minutes);

    // next scan position, wrapping after the last one
    assign n_position = (r_position >= mcds_pkg::POS_LAST) ? 3'd0 : (r_position + 3'd1);

    // pattern for the new position, before inversion
    always_comb begin
        unique case (n_position)
            3'd0:    n_word = mcds_pkg::f_seg(r_digits[0]) | mcds_pkg::f_sel_mask(n_position);
            3'd1:    n_word = mcds_pkg::f_seg(r_digits[1]) | mcds_pkg::f_sel_mask(n_position);
            3'd3:    n_word = mcds_pkg::f_seg(r_digits[2]) | mcds_pkg::f_sel_mask(n_position);
            3'd4:    n_word = mcds_pkg::f_seg(r_digits[3]) | mcds_pkg::f_sel_mask(n_position);
            default: n_word = mcds_pkg::f_sel_mask(mcds_pkg::POS_COLON)
                              | (r_colon ? mcds_pkg::COLON_MASK : 16'h0000);
        endcase
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (in_accept) begin
            r_op      <= i_op;
            r_hours   <= i_hours;
            r_minutes <= i_minutes;
        end
    end

    // state update and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digits[0] <= 4'd0;
            r_digits[1] <= 4'd0;
            r_digits[2] <= 4'd0;
            r_digits[3] <= 4'd0;
            r_colon     <= 1'b0;
            r_position  <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            // a new scan beat refills the slot even as the old one leaves
            if (scan_step) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_in_valid && advance) begin
                unique case (r_op)
                    mcds_pkg::OP_SET_TIME: begin
                        r_digits[0] <= split_m.units;
                        r_digits[1] <= split_m.tens;
                        r_digits[2] <= split_h.units;
                        r_digits[3] <= split_h.tens;
                    end
                    mcds_pkg::OP_BLINK: begin
                        r_colon <= !r_colon;
                    end
                    mcds_pkg::OP_SCAN: begin
                        r_position <= n_position;
                    end
                    default: begin
                        // unused op code: no effect
                    end
                endcase
            end
        end
    end

    // result payload, loaded only by a scan beat
    always_ff @(posedge i_clk) begin
        if (scan_step) begin
            r_drive_word    <= ~n_word;
            r_scan_position <= n_position;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_drive_word    = r_drive_word;
    assign o_scan_position = r_scan_position;

    // ---- checks ----
    `MCDS_ASSERT_SAME(a_position_range, i_clk, i_rst_n, 1'b1, r_position <= mcds_pkg::POS_LAST)
    `MCDS_ASSERT_SAME(a_digits_decimal, i_clk, i_rst_n, 1'b1,
        (r_digits[0] <= 4'd9) && (r_digits[1] <= 4'd9)
        && (r_digits[2] <= 4'd9) && (r_digits[3] <= 4'd9))
    `MCDS_ASSERT_NEXT(a_scan_gives_beat, i_clk, i_rst_n, scan_step,
        r_out_valid && (r_scan_position == r_position))
    `MCDS_ASSERT_SAME(a_colon_word, i_clk, i_rst_n,
        r_out_valid && (r_scan_position == mcds_pkg::POS_COLON),
        (r_drive_word == 16'hFF7F) || (r_drive_word == 16'hEF3F))

endmodule

`default_nettype wire

// ----- sim/multiplexed_clock_display_scanner_test.sv -----
`default_nettype none

// tracks the display state and holds the drive words that scan beats must produce
class display_scoreboard;

    logic [3:0]  digit_q [4];
    bit          colon_lit;
    logic [2:0]  scan_pos;
    logic [15:0] glyph_tab [10];
    logic [15:0] select_tab [5];
    logic [15:0] word_q [$];
    logic [2:0]  pos_q [$];
    int          errors;

    function new();
        glyph_tab  = '{16'h095C, 16'h0110, 16'h1854, 16'h1154, 16'h1118,
                       16'h114C, 16'h194C, 16'h011C, 16'h195C, 16'h115C};
        select_tab = '{16'h0002, 16'h0020, 16'h0080, 16'h0400, 16'h2000};
        foreach (digit_q[k]) digit_q[k] = 4'd0;
        colon_lit = 1'b0;
        scan_pos  = 3'd0;
        errors    = 0;
    endfunction

    // one accepted input beat: update the display state, queue a word on a scan
    function void note_beat(logic [1:0] op, logic [6:0] hrs, logic [6:0] mins);
        logic [15:0] pattern;
        logic [3:0]  d;
        int          slot;
        case (op)
            mcds_pkg::OP_SET_TIME: begin
                digit_q[0] = 4'(mins % 7'd10);
                digit_q[1] = 4'((mins / 7'd10) % 7'd10);
                digit_q[2] = 4'(hrs % 7'd10);
                digit_q[3] = 4'((hrs / 7'd10) % 7'd10);
            end
            mcds_pkg::OP_BLINK: begin
                colon_lit = !colon_lit;
            end
            mcds_pkg::OP_SCAN: begin
                scan_pos = (scan_pos >= mcds_pkg::POS_LAST) ? 3'd0 : scan_pos + 3'd1;
                if (scan_pos == mcds_pkg::POS_COLON) begin
                    pattern = select_tab[mcds_pkg::POS_COLON]
                              | (colon_lit ? mcds_pkg::COLON_MASK : 16'h0000);
                end else begin
                    // positions above the colon hold the hour digits
                    slot    = (scan_pos > mcds_pkg::POS_COLON) ? int'(scan_pos) - 1
                                                               : int'(scan_pos);
                    d       = digit_q[slot];
                    pattern = ((d < 4'd10) ? glyph_tab[d] : 16'h0000) | select_tab[scan_pos];
                end
                word_q.push_back(~pattern);
                pos_q.push_back(scan_pos);
            end
            default: ;
        endcase
    endfunction

    // one accepted output beat against the oldest expected word
    function void check_word(logic [15:0] word, logic [2:0] pos);
        logic [15:0] exp_word;
        logic [2:0]  exp_pos;
        if (word_q.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected drive word %h at position %0d", word, pos);
            return;
        end
        exp_word = word_q.pop_front();
        exp_pos  = pos_q.pop_front();
        if (word !== exp_word || pos !== exp_pos) begin
            errors++;
            if (errors <= 10)
                $display("drive word mismatch: expected %h pos %0d, got %h pos %0d",
                         exp_word, exp_pos, word, pos);
        end
    endfunction

    function int pending();
        return word_q.size();
    endfunction

endclass

module multiplexed_clock_display_scanner_test;

    // op code the block has no use for, it must leave no trace
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_BEATS = 525;
    localparam int QUIET_TAIL   = 80;
    localparam int STALL_LIMIT  = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_op;
    logic [6:0]  i_hours;
    logic [6:0]  i_minutes;
    logic        o_valid;
    logic        i_ready;
    logic [15:0] o_drive_word;
    logic [2:0]  o_scan_position;

    display_scoreboard sb;

    // idling switches, flipped per stretch of the random part
    bit tx_gaps;
    bit rx_stalls;
    int quiet_cycles = 0;

    multiplexed_clock_display_scanner uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_op            (i_op),
        .i_hours         (i_hours),
        .i_minutes       (i_minutes),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_drive_word    (o_drive_word),
        .o_scan_position (o_scan_position)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // both channels sampled at the edge, before any of this edge's updates land
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                sb.note_beat(i_op, i_hours, i_minutes);
            if (o_valid && i_ready)
                sb.check_word(o_drive_word, o_scan_position);
        end
    end

    // watchdog: too long without a beat on either side means the block is stuck
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // receiver: ready drops in bursts of random length while stalls are allowed
    initial begin
        int rx_hold;
        rx_hold = 0;
        i_ready <= 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (rx_hold > 0) begin
                rx_hold--;
                i_ready <= (rx_hold == 0);
            end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
                rx_hold = $urandom_range(1, 6);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // present one beat, optionally after a gap, and hold it until it is taken
    task automatic send_beat(input logic [1:0] op, input logic [6:0] hrs,
                             input logic [6:0] mins);
        int gap;
        if (tx_gaps && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 6);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_op      <= op;
        i_hours   <= hrs;
        i_minutes <= mins;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // sender holds off until every queued drive word has come out
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
        @(posedge i_clk);
    endtask

    function automatic logic [1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)      return mcds_pkg::OP_SCAN;
        else if (r < 76) return mcds_pkg::OP_SET_TIME;
        else if (r < 94) return mcds_pkg::OP_BLINK;
        else             return OP_UNUSED;
    endfunction

    initial begin
        int          n;
        bit          drained_mid;
        logic [1:0]  op;
        logic [6:0]  hrs;
        logic [6:0]  mins;

        sb           = new();
        n            = 0;
        drained_mid  = 1'b0;
        tx_gaps      = 1'b1;
        rx_stalls    = 1'b1;
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_op      <= mcds_pkg::OP_SET_TIME;
        i_hours   <= 7'd0;
        i_minutes <= 7'd0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // full sweep from reset: zero digits, colon dark, wrap from 4 to 0;
        // hours and minutes on a scan must be ignored
        repeat (5) send_beat(mcds_pkg::OP_SCAN, 7'd127, 7'd127);
        send_beat(mcds_pkg::OP_SET_TIME, 7'd12, 7'd34);
        send_beat(mcds_pkg::OP_BLINK, 7'd127, 7'd127);
        repeat (5) send_beat(mcds_pkg::OP_SCAN, 7'd0, 7'd0);
        // values above 99 keep only two decimal digits
        send_beat(mcds_pkg::OP_SET_TIME, 7'd127, 7'd127);
        send_beat(OP_UNUSED, 7'd127, 7'd127);
        repeat (5) send_beat(mcds_pkg::OP_SCAN, 7'd85, 7'd42);
        send_beat(mcds_pkg::OP_BLINK, 7'd0, 7'd0);
        send_beat(mcds_pkg::OP_SET_TIME, 7'd99, 7'd99);
        send_beat(OP_UNUSED, 7'd0, 7'd0);
        send_beat(mcds_pkg::OP_SET_TIME, 7'd0, 7'd0);
        repeat (3) send_beat(mcds_pkg::OP_SCAN, 7'd0, 7'd127);
        drain_results();

        // random part: mostly scans, with set-time, blink and unused ops mixed in
        while (n < RANDOM_BEATS) begin
            if (n % 60 == 0) begin
                tx_gaps   = ($urandom_range(0, 3) != 0);
                rx_stalls = ($urandom_range(0, 3) != 0);
            end
            // tail of the run goes flat out on both sides
            if (n >= RANDOM_BEATS - QUIET_TAIL) begin
                tx_gaps   = 1'b0;
                rx_stalls = 1'b0;
            end
            if (n == RANDOM_BEATS / 2 && !drained_mid) begin
                drained_mid = 1'b1;
                drain_results();
            end
            op = pick_op();
            if (op == mcds_pkg::OP_SET_TIME && $urandom_range(0, 1) == 0) begin
                hrs  = 7'($urandom_range(0, 99));
                mins = 7'($urandom_range(0, 99));
            end else begin
                hrs  = 7'($urandom_range(0, 127));
                mins = 7'($urandom_range(0, 127));
            end
            send_beat(op, hrs, mins);
            if (op != OP_UNUSED)
                n++;
        end

        drain_results();
        // idle on to catch stray beats
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
